[rtl/core/tree_axis_pruner_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tree axis pruner
// Each macro expects signals named clk and arst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef TREE_AXIS_PRUNER_TOP_ASSERT_SVH
`define TREE_AXIS_PRUNER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TAP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TAP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tap_pkg.sv]
// ----------------------------------------------------------------------------
// tap_pkg
// Shared widths, function codes and table entry layouts of the tree pruner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tap_pkg;

	localparam int LINK_W        = 11;
	localparam int IDX_W         = 10;
	localparam int CNT_W         = 11;
	localparam int DEF_MAX_NODES = 1024;

	localparam logic [LINK_W-1:0] NO_LINK = '1;

	typedef enum logic [1:0] {
		FUNC_LOAD = 2'd0,
		FUNC_RUN  = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	// Source node as loaded.
	typedef struct packed {
		logic [LINK_W-1:0] medial;
		logic [LINK_W-1:0] lateral;
		logic              acc;
	} src_entry_t;

	// Pending lateral chain on the walk stack.
	typedef struct packed {
		logic [IDX_W-1:0]  src;
		logic [LINK_W-1:0] parent;
	} frame_t;

	// Kept entry: new parent, source node, and whether it opened a chain.
	typedef struct packed {
		logic [LINK_W-1:0] parent;
		logic [IDX_W-1:0]  src;
		logic              first;
	} meta_t;

endpackage

[rtl/core/tap_ram.sv]
// ----------------------------------------------------------------------------
// tap_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/tree_axis_pruner_top.sv]
// ----------------------------------------------------------------------------
// tree_axis_pruner_top
// Binary tree pruner: loads a node table, walks it depth first and keeps the
// accepted part with dense indices, then serves the kept entries.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid / in_stall | func, node_index, links, ...
//   out     | output    | out_valid/out_stall | kept_count, parent/medial/...
//
// A load request is answered from the idle state. A read request fetches
// the kept entry and then its successor from the metadata RAM one after
// the other, since a medial child is always the next dense index.
// A run visits each node in the check state, plus a lateral write state
// per chain that starts with a lateral link (the lateral RAM write port is
// shared), pop and pop-data states per stack pop, then an empty pop and the
// done state. The source RAM's registered read sets the chain loop's speed.
// Reset clears the control state and the kept count; the RAMs are not
// cleared. A stalled result stays in the output register; a new request is
// taken while it is being handed over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tree_axis_pruner_top
	import tap_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic [IDX_W-1:0]         node_index,
	input  logic signed [LINK_W-1:0] medial_link,
	input  logic signed [LINK_W-1:0] lateral_link,
	input  logic                     accepted,
	input  logic [CNT_W-1:0]         node_count,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [CNT_W-1:0]         kept_count,
	output logic signed [LINK_W-1:0] parent_out,
	output logic signed [LINK_W-1:0] medial_out,
	output logic signed [LINK_W-1:0] lateral_out,
	output logic [IDX_W-1:0]         source_index
);

	localparam int AW  = $clog2(MAX_NODES);
	localparam int SPW = $clog2(MAX_NODES + 1);
	localparam logic [SPW-1:0] SP_FULL = SPW'(MAX_NODES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_LATW,
		ST_POP,
		ST_POPD,
		ST_DONE,
		ST_RD1,
		ST_RD2
	} state_t;

	state_t state_q;

	// Walk registers.
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  kept_q;
	logic [CNT_W-1:0]  total_q;
	logic [SPW-1:0]    sp_q;
	logic [IDX_W-1:0]  cur_q;
	logic [LINK_W-1:0] par_q;
	logic [LINK_W-1:0] latp_q;
	logic              first_q;
	logic              mv_q;

	// Read request registers.
	logic [IDX_W-1:0]  idx_q;
	meta_t             meta0_q;
	logic [LINK_W-1:0] lat0_q;

	// Output register.
	logic              out_valid_q;
	logic [CNT_W-1:0]  kept_count_q;
	logic [LINK_W-1:0] parent_q;
	logic [LINK_W-1:0] medial_q;
	logic [LINK_W-1:0] lateral_q;
	logic [IDX_W-1:0]  source_q;

	// RAM ports.
	logic              src_we, src_re;
	logic [AW-1:0]     src_waddr, src_raddr;
	src_entry_t        src_wdata, src_rd;
	logic              stk_we, stk_re;
	logic [AW-1:0]     stk_waddr, stk_raddr;
	frame_t            stk_wdata, stk_rd;
	logic              meta_we, meta_re;
	logic [AW-1:0]     meta_waddr, meta_raddr;
	meta_t             meta_wdata, meta_rd;
	logic              lat_we, lat_re;
	logic [AW-1:0]     lat_waddr, lat_raddr;
	logic [LINK_W-1:0] lat_wdata, lat_rd;

	logic              in_acc;
	logic              slot_free;
	logic              out_load;
	logic [CNT_W-1:0]  n_in;
	logic              load_ok;
	logic              node_ok, lat_ok, med_ok, need_latw;
	logic [CNT_W-1:0]  idx_p1;
	logic              rd_in_range, rd_has_med;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;

	// A new result enters the output register: loads and unknown codes at
	// once, runs and reads from their final state.
	assign out_load = ((state_q == ST_IDLE) && in_acc && (func_t'(func) != FUNC_RUN) &&
		(func_t'(func) != FUNC_READ)) ||
		(((state_q == ST_DONE) || (state_q == ST_RD2)) && slot_free);

	// Node count saturates at the table size.
	assign n_in    = (32'(node_count) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
	assign load_ok = 32'(node_index) < 32'(MAX_NODES);

	// Decisions on the source entry that has just come out of the RAM.
	assign node_ok   = src_rd.acc && (kept_q < n_q);
	assign lat_ok    = !src_rd.lateral[LINK_W-1] &&
		({1'b0, src_rd.lateral[IDX_W-1:0]} < n_q) && (sp_q < SP_FULL);
	assign med_ok    = !src_rd.medial[LINK_W-1] &&
		({1'b0, src_rd.medial[IDX_W-1:0]} < n_q);
	assign need_latw = first_q && !par_q[LINK_W-1];

	// A medial child always gets the next dense index, so entry k has one
	// exactly when entry k+1 exists and did not open a chain of its own.
	assign idx_p1      = {1'b0, idx_q} + CNT_W'(1);
	assign rd_in_range = {1'b0, idx_q} < total_q;
	assign rd_has_med  = (idx_p1 < total_q) && !meta_rd.first;

	always_comb begin
		src_we     = 1'b0;
		src_waddr  = AW'(node_index);
		src_wdata  = '{medial: medial_link, lateral: lateral_link, acc: accepted};
		src_re     = 1'b0;
		src_raddr  = '0;
		stk_we     = 1'b0;
		stk_waddr  = AW'(sp_q);
		stk_wdata  = '{src: src_rd.lateral[IDX_W-1:0], parent: kept_q};
		stk_re     = 1'b0;
		stk_raddr  = AW'(sp_q - SPW'(1));
		meta_we    = 1'b0;
		meta_waddr = AW'(kept_q);
		meta_wdata = '{parent: par_q, src: cur_q, first: first_q};
		meta_re    = 1'b0;
		meta_raddr = AW'(node_index);
		lat_we     = 1'b0;
		lat_waddr  = AW'(kept_q);
		lat_wdata  = NO_LINK;
		lat_re     = 1'b0;
		lat_raddr  = AW'(node_index);
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (func_t'(func))
						FUNC_LOAD: begin
							src_we = load_ok;
						end
						FUNC_RUN: begin
							src_re = (n_in != '0);
						end
						FUNC_READ: begin
							meta_re = 1'b1;
							lat_re  = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_CHK: begin
				if (node_ok) begin
					meta_we = 1'b1;
					lat_we  = 1'b1;
					stk_we  = lat_ok;
					if (!need_latw && med_ok) begin
						src_re    = 1'b1;
						src_raddr = AW'(src_rd.medial[IDX_W-1:0]);
					end
				end
			end
			ST_LATW: begin
				lat_we    = 1'b1;
				lat_waddr = AW'(latp_q);
				lat_wdata = par_q;
				src_re    = mv_q;
				src_raddr = AW'(cur_q);
			end
			ST_POP: begin
				stk_re = (sp_q != '0);
			end
			ST_POPD: begin
				src_re    = 1'b1;
				src_raddr = AW'(stk_rd.src);
			end
			ST_RD1: begin
				meta_re    = 1'b1;
				meta_raddr = AW'(idx_p1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			kept_q       <= '0;
			total_q      <= '0;
			sp_q         <= '0;
			cur_q        <= '0;
			par_q        <= NO_LINK;
			latp_q       <= NO_LINK;
			first_q      <= 1'b0;
			mv_q         <= 1'b0;
			idx_q        <= '0;
			meta0_q      <= '0;
			lat0_q       <= NO_LINK;
			out_valid_q  <= 1'b0;
			kept_count_q <= '0;
			parent_q     <= NO_LINK;
			medial_q     <= NO_LINK;
			lateral_q    <= NO_LINK;
			source_q     <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (func_t'(func))
							FUNC_RUN: begin
								n_q     <= n_in;
								kept_q  <= '0;
								sp_q    <= '0;
								cur_q   <= '0;
								par_q   <= NO_LINK;
								first_q <= 1'b1;
								if (n_in == '0) begin
									total_q <= '0;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_CHK;
								end
							end
							FUNC_READ: begin
								idx_q   <= node_index;
								state_q <= ST_RD1;
							end
							default: begin
								// Loads and unknown codes answer at once.
								kept_count_q <= total_q;
								parent_q     <= NO_LINK;
								medial_q     <= NO_LINK;
								lateral_q    <= NO_LINK;
								source_q     <= '0;
							end
						endcase
					end
				end
				ST_CHK: begin
					if (node_ok) begin
						kept_q <= kept_q + CNT_W'(1);
						if (lat_ok) begin
							sp_q <= sp_q + SPW'(1);
						end
						cur_q   <= src_rd.medial[IDX_W-1:0];
						par_q   <= kept_q;
						first_q <= 1'b0;
						if (need_latw) begin
							latp_q  <= par_q;
							mv_q    <= med_ok;
							state_q <= ST_LATW;
						end else if (!med_ok) begin
							state_q <= ST_POP;
						end
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_LATW: begin
					state_q <= mv_q ? ST_CHK : ST_POP;
				end
				ST_POP: begin
					if (sp_q == '0) begin
						total_q <= kept_q;
						state_q <= ST_DONE;
					end else begin
						sp_q    <= sp_q - SPW'(1);
						state_q <= ST_POPD;
					end
				end
				ST_POPD: begin
					cur_q   <= stk_rd.src;
					par_q   <= stk_rd.parent;
					first_q <= 1'b1;
					state_q <= ST_CHK;
				end
				ST_DONE: begin
					if (slot_free) begin
						kept_count_q <= total_q;
						parent_q     <= NO_LINK;
						medial_q     <= NO_LINK;
						lateral_q    <= NO_LINK;
						source_q     <= '0;
						state_q      <= ST_IDLE;
					end
				end
				ST_RD1: begin
					meta0_q <= meta_rd;
					lat0_q  <= lat_rd;
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					if (slot_free) begin
						kept_count_q <= total_q;
						if (rd_in_range) begin
							parent_q  <= meta0_q.parent;
							medial_q  <= rd_has_med ? idx_p1 : NO_LINK;
							lateral_q <= lat0_q;
							source_q  <= meta0_q.src;
						end else begin
							parent_q  <= NO_LINK;
							medial_q  <= NO_LINK;
							lateral_q <= NO_LINK;
							source_q  <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kept_count   = kept_count_q;
	assign parent_out   = parent_q;
	assign medial_out   = medial_q;
	assign lateral_out  = lateral_q;
	assign source_index = source_q;

	// Source node table.
	tap_ram #(.WIDTH($bits(src_entry_t)), .DEPTH(MAX_NODES)) u_src_ram (
		.clk(clk), .we(src_we), .waddr(src_waddr), .wdata(src_wdata),
		.re(src_re), .raddr(src_raddr), .rdata(src_rd)
	);

	// Stack of lateral chains still to walk.
	tap_ram #(.WIDTH($bits(frame_t)), .DEPTH(MAX_NODES)) u_stk_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
	);

	// Kept entries: parent, source and chain-start flag.
	tap_ram #(.WIDTH($bits(meta_t)), .DEPTH(MAX_NODES)) u_meta_ram (
		.clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
		.re(meta_re), .raddr(meta_raddr), .rdata(meta_rd)
	);

	// Kept entries: lateral child, written empty first and linked later.
	tap_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_lat_ram (
		.clk(clk), .we(lat_we), .waddr(lat_waddr), .wdata(lat_wdata),
		.re(lat_re), .raddr(lat_raddr), .rdata(lat_rd)
	);

endmodule

[rtl/core/tap_checker.sv]
// ----------------------------------------------------------------------------
// tap_checker
// Port-level checks of the tree pruner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tap_checker
	import tap_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [1:0]               func,
	input logic [IDX_W-1:0]         node_index,
	input logic signed [LINK_W-1:0] medial_link,
	input logic signed [LINK_W-1:0] lateral_link,
	input logic                     accepted,
	input logic [CNT_W-1:0]         node_count,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [CNT_W-1:0]         kept_count,
	input logic signed [LINK_W-1:0] parent_out,
	input logic signed [LINK_W-1:0] medial_out,
	input logic signed [LINK_W-1:0] lateral_out,
	input logic [IDX_W-1:0]         source_index
);

	`include "tree_axis_pruner_top_assert.svh"

	// A pending result is not dropped while it is stalled.
	`TAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")

	// A load request answers in the next cycle.
	`TAP_ASSERT_NEXT(a_load_answer, in_valid && !in_stall && func == FUNC_LOAD,
		out_valid, "load request not answered")

	// A run request keeps the block busy in the following cycle.
	`TAP_ASSERT_NEXT(a_run_busy, in_valid && !in_stall && func == FUNC_RUN,
		in_stall, "run request did not start a walk")

	// A medial child is always a later dense index, never the root.
	`TAP_ASSERT_NOW(a_medial_pos, out_valid && medial_out != NO_LINK,
		medial_out != '0 && !medial_out[LINK_W-1], "bad medial index")

endmodule

bind tree_axis_pruner_top tap_checker u_tap_checker (.*);
